// ===== rtl/core/sst_pkg.sv =====
// Package for the sorted set table: request codes, register map and cell control type.
// No dependencies; imported by sst_cell and sorted_set_table_core.
package sst_pkg;

    // request codes
    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_ERASE    = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_FETCH    = 2'd3
    } sst_mode_t;

    // register map (byte addresses)
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    localparam logic [6:0] CAPACITY_RESET = 7'd64;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic cmp;   // latch compare flags against the request value
        logic ins;   // open a slot at the insert point, shift larger values up
        logic del;   // close the slot of the matching value, shift larger values down
    } sst_cell_ctrl_t;

endpackage

// ===== rtl/core/sst_cell.sv =====
// One cell of the sorted chain: holds one value and its compare flags.
// Depends on sst_pkg; instantiated in a row by sorted_set_table_core.
module sst_cell #(
    parameter int ITEM_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sst_pkg::sst_cell_ctrl_t ctrl,
    input  logic                    valid,      // this cell lies below the fill count
    input  logic [ITEM_WIDTH-1:0]   key,        // request value
    input  logic                    left_lt,    // lower neighbor holds a smaller value
    input  logic [ITEM_WIDTH-1:0]   left_val,
    input  logic [ITEM_WIDTH-1:0]   right_val,
    output logic                    lt,
    output logic                    eq,
    output logic [ITEM_WIDTH-1:0]   val
);
    import sst_pkg::*;

    logic [ITEM_WIDTH-1:0] val_reg, val_next;
    logic                  lt_reg, eq_reg;

    // compare flags, taken once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.cmp)
        begin
            lt_reg <= valid && (val_reg < key);
            eq_reg <= valid && (val_reg == key);
        end
    end

    // shift up on insert, down on erase; cells holding smaller values keep theirs
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins && !lt_reg)
        begin
            if (left_lt)
                val_next = key;
            else
                val_next = left_val;
        end
        else if (ctrl.del && !lt_reg)
        begin
            val_next = right_val;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign lt  = lt_reg;
    assign eq  = eq_reg;
    assign val = val_reg;

endmodule

// ===== rtl/core/sorted_set_table_core.sv =====
// Sorted set table top level: request sequencer, fill count, config register, cell row.
// Depends on sst_pkg and sst_cell.
//
// A request is taken when start is high and busy is low. It then passes through
// a compare pass, where every cell checks its value against the request value
// in parallel, and the update, where the row shifts by one cell to open or
// close a slot. The result is registered from the update: done is high for
// exactly one cycle, and ok/fetched/count are loaded with it and held until the
// next result; it must be taken then, as the block cannot be held off. busy is
// high through the compare pass and the update, so a new request is taken only
// after the previous one has left the update. The table needs no clearing after
// reset: only cells below the fill count are ever read. capacity may be written at
// any idle time; lowering it below the fill count keeps the values held.
module sorted_set_table_core #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] value,
    input  logic [5:0]  rank_index,
    // result
    output logic        done,
    output logic        ok,
    output logic [31:0] fetched,
    output logic [6:0]  count,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [6:0]            capacity_reg;
    sst_mode_t             mode_reg;
    logic [ITEM_WIDTH-1:0] key_reg;
    logic [5:0]            rank_reg;

    logic                  done_reg;
    logic                  ok_reg, ok_next;
    logic [31:0]           fetched_reg, fetched_next;
    logic [6:0]            count_reg;

    logic                  accept;
    sst_cell_ctrl_t        ctrl;
    logic [CAPACITY-1:0]   lt_vec, eq_vec;
    logic [ITEM_WIDTH-1:0] cell_val [CAPACITY];

    logic [63:0]           value64;
    logic [CW-1:0]         fill_ext, cap_ext, limit;
    logic                  found, room, ins_ok, rank_ok;
    logic [15:0]           rank16;
    logic [IDX_W-1:0]      fetch_idx;
    logic [63:0]           fetch64;
    logic [15:0]           fill16;

    assign accept  = start && !busy;
    assign value64 = 64'(value);

    // request sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_CMP;
            S_CMP:  state_next = S_EXEC;
            S_EXEC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    // latched request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= sst_mode_t'(mode);
            key_reg  <= value64[ITEM_WIDTH-1:0];
            rank_reg <= rank_index;
        end
    end

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAPACITY_RESET;
        else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY)
            capacity_reg <= pwdata[6:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    // decisions from the registered compare flags
    assign fill_ext = CW'(fill_reg);
    assign cap_ext  = CW'(capacity_reg);
    assign limit    = (cap_ext < CW'(CAPACITY)) ? cap_ext : CW'(CAPACITY);
    assign found    = |eq_vec;
    assign room     = fill_ext < limit;
    assign ins_ok   = room && !found;
    assign rank_ok  = CW'(rank_reg) < fill_ext;
    assign rank16   = 16'(rank_reg);
    assign fetch_idx = rank16[IDX_W-1:0];

    assign ctrl.cmp = (state_reg == S_CMP);
    assign ctrl.ins = (state_reg == S_EXEC) && (mode_reg == MODE_INSERT) && ins_ok;
    assign ctrl.del = (state_reg == S_EXEC) && (mode_reg == MODE_ERASE) && found;

    // cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                  left_lt_w;
        logic [ITEM_WIDTH-1:0] left_val_w, right_val_w;

        if (i == 0)
        begin : g_first
            assign left_lt_w  = 1'b1;
            assign left_val_w = key_reg;
        end
        else
        begin : g_mid
            assign left_lt_w  = lt_vec[i-1];
            assign left_val_w = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_val_w = cell_val[i];
        end
        else
        begin : g_next
            assign right_val_w = cell_val[i+1];
        end

        sst_cell #(
            .ITEM_WIDTH(ITEM_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .valid     (CW'(i) < fill_ext),
            .key       (key_reg),
            .left_lt   (left_lt_w),
            .left_val  (left_val_w),
            .right_val (right_val_w),
            .lt        (lt_vec[i]),
            .eq        (eq_vec[i]),
            .val       (cell_val[i])
        );
    end

    // fill count
    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.ins)
            fill_next = fill_reg + CNT_W'(1);
        else if (ctrl.del)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    // result
    assign fetch64 = 64'(cell_val[fetch_idx]);
    assign fill16  = 16'(fill_next);

    always_comb
    begin
        ok_next      = 1'b0;
        fetched_next = 32'd0;
        case (mode_reg)
            MODE_INSERT:   ok_next = ins_ok;
            MODE_ERASE:    ok_next = found;
            MODE_CONTAINS: ok_next = found;
            MODE_FETCH:
            begin
                ok_next = rank_ok;
                if (rank_ok)
                    fetched_next = fetch64[31:0];
            end
            default:       ok_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == S_EXEC);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            ok_reg      <= ok_next;
            fetched_reg <= fetched_next;
            count_reg   <= fill16[6:0];
        end
    end

    assign done    = done_reg;
    assign ok      = ok_reg;
    assign fetched = fetched_reg;
    assign count   = count_reg;

    // checks
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without an update cycle");

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_CMP)
        else $error("accepted item did not enter the compare pass");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(fill_reg) <= CW'(CAPACITY))
        else $error("fill count above table size");

    a_fill_moves_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> $past(state_reg == S_EXEC))
        else $error("fill count changed outside an update cycle");

    a_no_double_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.ins && ctrl.del))
        else $error("insert and erase shift in the same cycle");

endmodule
